@@ hdl/ppgdc_pkg.sv @@
// Shared package for the optical pulse-signal DC removal and low-pass core.
// Holds the fixed-point widths, register reset values, register indexes,
// state machine encodings and the structs passed between modules. No dependencies.
package ppgdc_pkg;

  // Sample and fixed-point formats.
  localparam int SAMPLE_BITS = 18;
  localparam int FRAC_BITS   = 22;
  localparam int ACC_BITS    = SAMPLE_BITS + FRAC_BITS;
  localparam int DELAY_BITS  = SAMPLE_BITS + FRAC_BITS + 8;

  // Coefficients are Q2.22. Alpha is unsigned and one bit narrower.
  localparam int COEF_BITS  = 24;
  localparam int COEF_FRAC  = 22;
  localparam int ALPHA_BITS = 23;

  // Results are Q.8.
  localparam int OUT_BITS  = 26;
  localparam int OUT_FRAC  = 8;
  localparam int RND_SHIFT = FRAC_BITS - OUT_FRAC;

  // Shared multiplier: the data operand's magnitude is split into two halves.
  localparam int HALF_BITS = (DELAY_BITS + 1) / 2;
  localparam int HI_BITS   = DELAY_BITS - HALF_BITS;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ALPHA = 3'd0,
    REG_B0    = 3'd1,
    REG_B1    = 3'd2,
    REG_B2    = 3'd3,
    REG_A1    = 3'd4,
    REG_A2    = 3'd5
  } cfg_index_t;

  localparam logic [ALPHA_BITS-1:0]       ALPHA_RESET = 23'd20972;
  localparam logic signed [COEF_BITS-1:0] B0_RESET    = 24'sd84236;
  localparam logic signed [COEF_BITS-1:0] B1_RESET    = 24'sd168471;
  localparam logic signed [COEF_BITS-1:0] B2_RESET    = 24'sd84236;
  localparam logic signed [COEF_BITS-1:0] A1_RESET    = -24'sd6547384;
  localparam logic signed [COEF_BITS-1:0] A2_RESET    = 24'sd2690023;

  typedef struct packed {
    logic [ALPHA_BITS-1:0]       alpha;
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_set_t;

  // Request to and response from the shared multiplier.
  typedef struct packed {
    logic                         start;
    logic signed [DELAY_BITS-1:0] a;
    logic signed [COEF_BITS:0]    c;
  } mul_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [DELAY_BITS-1:0] product;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_LO,
    MS_HI,
    MS_FIX
  } mul_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AC,
    ST_START,
    ST_WAIT,
    ST_RND,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_ALPHA,
    OP_B0,
    OP_B1,
    OP_B2,
    OP_A1,
    OP_A2
  } op_t;

endpackage

@@ hdl/ppgdc_regs.sv @@
// Configuration register file: alpha and the five biquad coefficients.
// Depends on ppgdc_pkg.
module ppgdc_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [ppgdc_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [ppgdc_pkg::CFG_DATA_BITS-1:0]  wr_data,
  output ppgdc_pkg::coef_set_t                 coefs
);
  import ppgdc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.alpha <= ALPHA_RESET;
      coefs.b0    <= B0_RESET;
      coefs.b1    <= B1_RESET;
      coefs.b2    <= B2_RESET;
      coefs.a1    <= A1_RESET;
      coefs.a2    <= A2_RESET;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        REG_ALPHA: coefs.alpha <= wr_data[ALPHA_BITS-1:0];
        REG_B0:    coefs.b0    <= $signed(wr_data[COEF_BITS-1:0]);
        REG_B1:    coefs.b1    <= $signed(wr_data[COEF_BITS-1:0]);
        REG_B2:    coefs.b2    <= $signed(wr_data[COEF_BITS-1:0]);
        REG_A1:    coefs.a1    <= $signed(wr_data[COEF_BITS-1:0]);
        REG_A2:    coefs.a2    <= $signed(wr_data[COEF_BITS-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/ppgdc_mul.sv @@
// Shared coefficient multiplier: signed data times signed Q2.22 coefficient,
// rounded half away from zero and saturated, on one narrow multiplier.
// Depends on ppgdc_pkg.
module ppgdc_mul (
  input  logic                clk,
  input  logic                rst,
  input  ppgdc_pkg::mul_req_t req,
  output ppgdc_pkg::mul_rsp_t rsp
);
  import ppgdc_pkg::*;

  localparam int PART_BITS = HALF_BITS + COEF_BITS;
  localparam int SUM_BITS  = DELAY_BITS + COEF_BITS + 1;
  localparam int MAG_BITS  = SUM_BITS - COEF_FRAC;
  localparam logic [SUM_BITS-1:0] RND_HALF = SUM_BITS'(1) << (COEF_FRAC - 1);
  localparam logic [MAG_BITS-1:0] POS_LIM =
    {{(MAG_BITS - DELAY_BITS + 1){1'b0}}, {(DELAY_BITS - 1){1'b1}}};
  localparam logic [MAG_BITS-1:0] NEG_LIM = POS_LIM + MAG_BITS'(1);

  mul_state_t state, state_next;

  logic [DELAY_BITS-1:0] ua;
  logic [COEF_BITS-1:0]  uc;
  logic                  neg;
  logic [PART_BITS-1:0]  part;
  logic [MAG_BITS-1:0]   mag;

  logic                         done;
  logic signed [DELAY_BITS-1:0] product;

  logic [DELAY_BITS-1:0] a_mag;
  logic [COEF_BITS:0]    c_mag;
  logic [HALF_BITS-1:0]  mul_x;
  logic [PART_BITS-1:0]  mul_p;
  logic [SUM_BITS-1:0]   sum;

  assign rsp = {done, product};

  // Magnitudes of the request operands.
  assign a_mag = req.a[DELAY_BITS-1] ? (~req.a + DELAY_BITS'(1)) : req.a;
  assign c_mag = req.c[COEF_BITS] ? (~req.c + (COEF_BITS + 1)'(1)) : req.c;

  // The one multiplier: low half first, then high half.
  assign mul_x = (state == MS_LO) ? ua[HALF_BITS-1:0]
                                  : HALF_BITS'(ua[DELAY_BITS-1:HALF_BITS]);
  assign mul_p = PART_BITS'(mul_x) * PART_BITS'(uc);
  assign sum   = (SUM_BITS'(mul_p) << HALF_BITS) + SUM_BITS'(part) + RND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MS_FIX);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      MS_IDLE: if (req.start) state_next = MS_LO;
      MS_LO:   state_next = MS_HI;
      MS_HI:   state_next = MS_FIX;
      MS_FIX:  state_next = MS_IDLE;
      default: state_next = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      MS_IDLE: begin
        if (req.start) begin
          ua  <= a_mag;
          uc  <= c_mag[COEF_BITS-1:0];
          neg <= req.a[DELAY_BITS-1] ^ req.c[COEF_BITS];
        end
      end
      MS_LO: part <= mul_p;
      MS_HI: mag <= sum[SUM_BITS-1:COEF_FRAC];
      MS_FIX: begin
        if (!neg) begin
          product <= (mag > POS_LIM) ? $signed(POS_LIM[DELAY_BITS-1:0])
                                     : $signed(mag[DELAY_BITS-1:0]);
        end else begin
          product <= (mag > NEG_LIM) ? $signed(NEG_LIM[DELAY_BITS-1:0])
                                     : $signed(~mag[DELAY_BITS-1:0] + DELAY_BITS'(1));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/ppg_dc_removal_lowpass_core.sv @@
// Optical pulse-signal front end: exponential baseline removal and a
// transposed direct form II low-pass biquad, sequenced over one multiplier.
// One sample is processed at a time; each of the up to six coefficient products
// (alpha is skipped for the first sample after reset) runs on the shared 24 by 24 unit.
// Reset (rst, synchronous): baseline unloaded, delays zero, registers to defaults.
module ppg_dc_removal_lowpass_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic [ppgdc_pkg::SAMPLE_BITS-1:0]    sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [ppgdc_pkg::OUT_BITS-1:0] filtered_ac,
  output logic [ppgdc_pkg::OUT_BITS-1:0]       baseline,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ppgdc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ppgdc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ppgdc_pkg::*;

  // Widths of the rounded output magnitudes and of the compares that clamp them.
  localparam int YQ_BITS = DELAY_BITS + 1 - RND_SHIFT;
  localparam int BQ_BITS = ACC_BITS + 1 - RND_SHIFT;
  localparam int YC_BITS = ((YQ_BITS > OUT_BITS) ? YQ_BITS : OUT_BITS) + 1;
  localparam int BC_BITS = ((BQ_BITS > OUT_BITS) ? BQ_BITS : OUT_BITS) + 1;
  localparam logic [YC_BITS-1:0] Y_POS_LIM = YC_BITS'({(OUT_BITS - 1){1'b1}});
  localparam logic [YC_BITS-1:0] Y_NEG_LIM = Y_POS_LIM + YC_BITS'(1);
  localparam logic [BC_BITS-1:0] B_LIM     = BC_BITS'({OUT_BITS{1'b1}});
  localparam logic signed [DELAY_BITS-1:0] D_MAX = {1'b0, {(DELAY_BITS - 1){1'b1}}};
  localparam logic signed [DELAY_BITS-1:0] D_MIN = {1'b1, {(DELAY_BITS - 1){1'b0}}};

  // Clamp a value two bits wider than the delay state into the delay range.
  function automatic logic signed [DELAY_BITS-1:0] sat_delay(
    input logic signed [DELAY_BITS+1:0] v
  );
    logic [2:0] top;
    top = v[DELAY_BITS+1:DELAY_BITS-1];
    if (top == 3'b000 || top == 3'b111) return v[DELAY_BITS-1:0];
    else if (v[DELAY_BITS+1]) return D_MIN;
    else return D_MAX;
  endfunction

  coef_set_t coefs;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;

  state_t state, state_next;
  op_t    op;

  // Filter state and working registers. The baseline accumulator and the two
  // delays carry FRAC_BITS fraction bits.
  logic [SAMPLE_BITS-1:0]       x_reg;
  logic [ACC_BITS-1:0]          base_acc;
  logic                         loaded;
  logic signed [DELAY_BITS-1:0] delay_one;
  logic signed [DELAY_BITS-1:0] delay_two;
  logic signed [ACC_BITS:0]     ac;
  logic signed [DELAY_BITS-1:0] y;
  logic signed [DELAY_BITS:0]   t1;
  logic signed [DELAY_BITS:0]   t2;
  logic [YQ_BITS-1:0]           yq_mag;
  logic                         y_neg;
  logic [BQ_BITS-1:0]           bq;

  logic                         sample_xfer;
  logic                         result_xfer;
  logic [ACC_BITS-1:0]          xs;
  logic signed [DELAY_BITS:0]   base_sum;
  logic [DELAY_BITS-1:0]        y_mag;
  logic [DELAY_BITS:0]          y_rnd;
  logic [ACC_BITS:0]            b_rnd;
  logic [YC_BITS-1:0]           yq_ext;
  logic [BC_BITS-1:0]           bq_ext;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  ppgdc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coefs    (coefs)
  );

  ppgdc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // A new sample is taken only when the sequencer is idle. The output register
  // keeps the previous result until its transfer, so the next sample can start
  // while the consumer is stalled.
  assign sample_stall = (state != ST_IDLE);
  assign sample_xfer  = sample_valid && !sample_stall;
  assign result_xfer  = result_valid && !result_stall;

  assign xs = {x_reg, {FRAC_BITS{1'b0}}};

  // Baseline moved by the alpha product; kept inside the accumulator's range.
  assign base_sum = $signed({{(DELAY_BITS - ACC_BITS + 1){1'b0}}, base_acc})
                  + (DELAY_BITS + 1)'(mul_rsp.product);

  // Rounding to Q.8, half away from zero, done on magnitudes.
  assign y_mag  = y[DELAY_BITS-1] ? (~y + DELAY_BITS'(1)) : y;
  assign y_rnd  = {1'b0, y_mag} + ((DELAY_BITS + 1)'(1) << (RND_SHIFT - 1));
  assign b_rnd  = {1'b0, base_acc} + ((ACC_BITS + 1)'(1) << (RND_SHIFT - 1));
  assign yq_ext = YC_BITS'(yq_mag);
  assign bq_ext = BC_BITS'(bq);

  // Sequencer: state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and the multiplier request. The operands come
  // straight from registers, so the unit always sees stable values.
  always_comb begin
    state_next    = state;
    mul_req.start = 1'b0;
    mul_req.a     = DELAY_BITS'(ac);
    mul_req.c     = {coefs.b0[COEF_BITS-1], coefs.b0};
    case (op)
      OP_ALPHA: mul_req.c = $signed({2'b00, coefs.alpha});
      OP_B0:    mul_req.c = {coefs.b0[COEF_BITS-1], coefs.b0};
      OP_B1:    mul_req.c = {coefs.b1[COEF_BITS-1], coefs.b1};
      OP_B2:    mul_req.c = {coefs.b2[COEF_BITS-1], coefs.b2};
      OP_A1: begin
        mul_req.a = y;
        mul_req.c = {coefs.a1[COEF_BITS-1], coefs.a1};
      end
      OP_A2: begin
        mul_req.a = y;
        mul_req.c = {coefs.a2[COEF_BITS-1], coefs.a2};
      end
      default: begin
      end
    endcase

    case (state)
      ST_IDLE: if (sample_xfer) state_next = ST_AC;
      ST_AC:   state_next = ST_START;
      ST_START: begin
        mul_req.start = 1'b1;
        state_next    = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_rsp.done) begin
          case (op)
            OP_ALPHA: state_next = ST_AC;
            OP_A2:    state_next = ST_RND;
            default:  state_next = ST_START;
          endcase
        end
      end
      ST_RND: state_next = ST_OUT;
      ST_OUT: if (!result_valid || !result_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers: baseline load flag, operation index and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded       <= 1'b0;
      op           <= OP_ALPHA;
      result_valid <= 1'b0;
    end else begin
      if (sample_xfer) begin
        loaded <= 1'b1;
        // The first sample loads the baseline directly and skips the alpha step.
        op     <= loaded ? OP_ALPHA : OP_B0;
      end
      if (state == ST_WAIT && mul_rsp.done) begin
        case (op)
          OP_ALPHA: op <= OP_B0;
          OP_B0:    op <= OP_B1;
          OP_B1:    op <= OP_B2;
          OP_B2:    op <= OP_A1;
          OP_A1:    op <= OP_A2;
          default:  op <= OP_ALPHA;
        endcase
      end
      if (state == ST_OUT && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_xfer) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Filter state. Reset clears the baseline and both delays.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_acc  <= '0;
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      if (sample_xfer && !loaded) begin
        base_acc <= {sample, {FRAC_BITS{1'b0}}};
      end
      if (state == ST_WAIT && mul_rsp.done) begin
        case (op)
          OP_ALPHA: begin
            if (base_sum[DELAY_BITS]) begin
              base_acc <= '0;
            end else if (base_sum[DELAY_BITS-1:ACC_BITS] != '0) begin
              base_acc <= '1;
            end else begin
              base_acc <= base_sum[ACC_BITS-1:0];
            end
          end
          OP_A2: begin
            // Both delays advance together; the first uses the old second delay.
            delay_one <= sat_delay((DELAY_BITS + 2)'(t1) + (DELAY_BITS + 2)'(delay_two));
            delay_two <= sat_delay((DELAY_BITS + 2)'(t2)
                                   - (DELAY_BITS + 2)'(mul_rsp.product));
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers of one sample; no reset needed.
  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      x_reg <= sample;
    end
    if (state == ST_AC) begin
      // On the alpha pass this is the error against the old baseline; after
      // the update it is the AC input to the biquad.
      ac <= $signed({1'b0, xs}) - $signed({1'b0, base_acc});
    end
    if (state == ST_WAIT && mul_rsp.done) begin
      case (op)
        OP_B0: y <= sat_delay((DELAY_BITS + 2)'(mul_rsp.product)
                              + (DELAY_BITS + 2)'(delay_one));
        OP_B1: t1 <= (DELAY_BITS + 1)'(mul_rsp.product);
        OP_B2: t2 <= (DELAY_BITS + 1)'(mul_rsp.product);
        OP_A1: t1 <= t1 - (DELAY_BITS + 1)'(mul_rsp.product);
        default: begin
        end
      endcase
    end
    if (state == ST_RND) begin
      yq_mag <= y_rnd[DELAY_BITS:RND_SHIFT];
      y_neg  <= y[DELAY_BITS-1];
      bq     <= b_rnd[ACC_BITS:RND_SHIFT];
    end
    if (state == ST_OUT && (!result_valid || !result_stall)) begin
      if (!y_neg) begin
        filtered_ac <= (yq_ext > Y_POS_LIM) ? $signed(Y_POS_LIM[OUT_BITS-1:0])
                                            : $signed(yq_ext[OUT_BITS-1:0]);
      end else begin
        filtered_ac <= (yq_ext > Y_NEG_LIM) ? $signed(Y_NEG_LIM[OUT_BITS-1:0])
                                            : $signed(~yq_ext[OUT_BITS-1:0]
                                                      + OUT_BITS'(1));
      end
      baseline <= (bq_ext > B_LIM) ? B_LIM[OUT_BITS-1:0] : bq_ext[OUT_BITS-1:0];
    end
  end

endmodule

@@ hdl/ppgdc_checker.sv @@
// Port-level checks for the DC removal and low-pass core, bound to the top level.
// Depends on ppgdc_pkg and ppg_dc_removal_lowpass_core.
module ppgdc_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  sample_valid,
  input logic                                  sample_stall,
  input logic                                  result_valid,
  input logic                                  result_stall,
  input logic signed [ppgdc_pkg::OUT_BITS-1:0] filtered_ac,
  input logic [ppgdc_pkg::OUT_BITS-1:0]        baseline
);
  import ppgdc_pkg::*;

  // A result that is not taken stays offered.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(filtered_ac) && $stable(baseline))
    else $error("result changed while stalled");

  // A sample transfer makes the block busy.
  a_busy_after_input: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("block not busy after sample transfer");

  // A new result appears only at the end of busy work.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(result_valid) |-> $past(sample_stall))
    else $error("result appeared without work");

  // The block becomes free only with a result on offer.
  a_free_with_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(sample_stall) |-> result_valid)
    else $error("block freed without a result");

endmodule

bind ppg_dc_removal_lowpass_core ppgdc_checker u_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ppg_dc_removal_lowpass_core: a scoreboard class that
// predicts baseline and filtered output per sample, plus tasks that drive the core.
// Depends on ppgdc_pkg and the core's RTL only.

import ppgdc_pkg::*;

localparam longint ACC_MAX  = (longint'(1) <<< ACC_BITS) - 1;
localparam longint DLY_MAX  = (longint'(1) <<< (DELAY_BITS - 1)) - 1;
localparam longint AC_MAX   = (longint'(1) <<< (OUT_BITS - 1)) - 1;
localparam longint BASE_MAX = (longint'(1) <<< OUT_BITS) - 1;
localparam int     MAX_SHOWN_MISMATCHES = 200;

typedef struct {
  logic signed [OUT_BITS-1:0] ac_q8;
  logic [OUT_BITS-1:0]        baseline_q8;
} q8_result_t;

class ppg_scoreboard;
  q8_result_t expected_results[$];
  int mismatches;
  int checked;

  // Baseline accumulator and biquad delays, all with FRAC_BITS fraction bits.
  longint acc_level;
  bit     acc_loaded;
  longint delay_one_q;
  longint delay_two_q;

  logic [ALPHA_BITS-1:0]       alpha;
  logic signed [COEF_BITS-1:0] b0, b1, b2, a1, a2;

  function new();
    alpha       = ALPHA_RESET;
    b0          = B0_RESET;
    b1          = B1_RESET;
    b2          = B2_RESET;
    a1          = A1_RESET;
    a2          = A2_RESET;
    acc_level   = 0;
    acc_loaded  = 0;
    delay_one_q = 0;
    delay_two_q = 0;
    mismatches  = 0;
    checked     = 0;
  endfunction

  function longint saturate_delay(longint v);
    if (v > DLY_MAX) return DLY_MAX;
    if (v < -DLY_MAX - 1) return -DLY_MAX - 1;
    return v;
  endfunction

  // Product with a Q2.22 coefficient, rounded half away from zero.
  function longint coef_product(longint a, longint c);
    longint mag_a, mag_c, m;
    logic [127:0] wide;
    mag_a = (a < 0) ? -a : a;
    mag_c = (c < 0) ? -c : c;
    wide  = 128'(mag_a) * 128'(mag_c) + (128'd1 << (COEF_FRAC - 1));
    m     = longint'(wide >> COEF_FRAC);
    if ((a < 0) != (c < 0)) m = -m;
    return saturate_delay(m);
  endfunction

  function longint to_q8(longint v);
    longint mag, u;
    mag = (v < 0) ? -v : v;
    u   = (mag + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    return (v < 0) ? -u : u;
  endfunction

  function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_ALPHA: alpha = data[ALPHA_BITS-1:0];
      REG_B0:    b0 = data;
      REG_B1:    b1 = data;
      REG_B2:    b2 = data;
      REG_A1:    a1 = data;
      REG_A2:    a2 = data;
      default:   ;
    endcase
  endfunction

  function void note_sample(logic [SAMPLE_BITS-1:0] x);
    longint xs, ac, y, ac_out, base_out;
    q8_result_t r;
    xs = longint'(x) <<< FRAC_BITS;
    if (!acc_loaded) begin
      acc_level  = xs;
      acc_loaded = 1;
    end else begin
      acc_level = acc_level + coef_product(xs - acc_level, longint'(alpha));
      if (acc_level < 0) acc_level = 0;
      else if (acc_level > ACC_MAX) acc_level = ACC_MAX;
    end
    ac = xs - acc_level;
    y  = saturate_delay(coef_product(ac, longint'(b0)) + delay_one_q);
    delay_one_q = saturate_delay(coef_product(ac, longint'(b1)) -
                                 coef_product(y, longint'(a1)) + delay_two_q);
    delay_two_q = saturate_delay(coef_product(ac, longint'(b2)) -
                                 coef_product(y, longint'(a2)));
    ac_out = to_q8(y);
    if (ac_out > AC_MAX) ac_out = AC_MAX;
    else if (ac_out < -AC_MAX - 1) ac_out = -AC_MAX - 1;
    base_out = to_q8(acc_level);
    if (base_out > BASE_MAX) base_out = BASE_MAX;
    r.ac_q8       = ac_out[OUT_BITS-1:0];
    r.baseline_q8 = base_out[OUT_BITS-1:0];
    expected_results.push_back(r);
  endfunction

  function void check_result(logic signed [OUT_BITS-1:0] ac_q8, logic [OUT_BITS-1:0] baseline_q8);
    q8_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN_MISMATCHES)
        $display("%0t: result with nothing expected: filtered_ac %0d baseline %0d",
                 $time, ac_q8, baseline_q8);
      return;
    end
    want = expected_results.pop_front();
    checked++;
    if (ac_q8 !== want.ac_q8) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN_MISMATCHES)
        $display("%0t: filtered_ac expected %0d actual %0d", $time, want.ac_q8, ac_q8);
    end
    if (baseline_q8 !== want.baseline_q8) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN_MISMATCHES)
        $display("%0t: baseline expected %0d actual %0d", $time, want.baseline_q8, baseline_q8);
    end
  endfunction
endclass

module testbench;
  // The limit lies well beyond the slowest item and the long output hold-off, so
  // that long without a single transfer can only mean a hang.
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int PRESSURE_PHASE  = 4;
  localparam int FULL_SCALE      = (1 << SAMPLE_BITS) - 1;

  // Indexes the core has no register behind; writes there must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {
    CFG_DEFAULT,
    CFG_MAX,
    CFG_MIN,
    CFG_UNITY_ALPHA,
    CFG_RANDOM,
    CFG_SLOW_ALPHA
  } coef_kind_t;

  // Idle modes per phase: none, heavy source gaps, heavy output stalls, light both.
  localparam int SEND_IDLE[4]  = '{0, 69, 0, 7};
  localparam int RECV_STALL[4] = '{0, 0, 69, 7};
  localparam coef_kind_t PHASE_KIND[NUM_PHASES] = '{
    CFG_DEFAULT, CFG_RANDOM, CFG_SLOW_ALPHA, CFG_UNITY_ALPHA,
    CFG_DEFAULT, CFG_RANDOM, CFG_MAX, CFG_MIN
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         sample_valid = 1'b0;
  logic                         sample_stall;
  logic [SAMPLE_BITS-1:0]       sample = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic signed [OUT_BITS-1:0]   filtered_ac;
  logic [OUT_BITS-1:0]          baseline;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_data = '0;

  ppg_scoreboard sb;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit pressure_phase = 1'b0;
  bit hold_used      = 1'b0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int samples_sent   = 0;
  int cfg_writes     = 0;
  int coef_settings  = 1;

  always #2 clk = ~clk;

  ppg_dc_removal_lowpass_core u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered_ac  (filtered_ac),
    .baseline     (baseline),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Both transfer monitors look at values from before the edge, so the order in
  // which processes wake at that edge does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        sb.note_sample(sample);
        samples_sent++;
      end
      if (result_valid && !result_stall)
        sb.check_result(filtered_ac, baseline);
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results still expected",
               $time, WATCHDOG_LIMIT, sb.expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side. It stalls at random at the phase's rate, and once, when the
  // pressure phase opens, it holds off for a long stretch that it counts itself
  // while the source keeps offering samples and the core backs up.
  always @(posedge clk) begin
    if (pressure_phase && !hold_used) begin
      hold_used    <= 1'b1;
      hold_left    <= HOLD_OFF_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one sample, after random idle cycles, and returns at the edge where
  // it transfers. Valid stays high so back-to-back samples need no extra step.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Stops the source and waits until every expected result has been checked.
  // The first edge is always waited for, so a sample that transferred at the
  // current edge is already on the scoreboard when the queue is looked at.
  task automatic wait_for_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_writes++;
  endtask

  // Writes a full coefficient set while the core is idle. Alpha is sent as a
  // 24-bit word, so the top bit of the data, which alpha does not use, is
  // exercised as well. Both unused indexes get random data each time.
  task automatic load_coefs(input coef_kind_t kind);
    logic [CFG_DATA_BITS-1:0] alpha_w, b0_w, b1_w, b2_w, a1_w, a2_w;
    case (kind)
      CFG_MAX: begin
        // Alpha near two overshoots the baseline; full-scale coefficients make
        // the filter unstable so every saturation point gets hit.
        alpha_w = 24'hFFFFFF;
        b0_w = 24'h7FFFFF;
        b1_w = 24'h800000;
        b2_w = 24'h7FFFFF;
        a1_w = 24'h800000;
        a2_w = 24'h7FFFFF;
      end
      CFG_MIN: begin
        // Alpha of zero freezes the baseline after the first sample.
        alpha_w = 24'h800000;
        b0_w = 24'h800000;
        b1_w = 24'h800000;
        b2_w = 24'h800000;
        a1_w = 24'h7FFFFF;
        a2_w = 24'h800000;
      end
      CFG_UNITY_ALPHA: begin
        // An alpha of exactly one makes the baseline track each sample.
        alpha_w = 24'd4194304;
        b0_w = 24'($urandom);
        b1_w = 24'($urandom);
        b2_w = 24'($urandom);
        a1_w = 24'($urandom);
        a2_w = 24'($urandom);
      end
      CFG_RANDOM: begin
        alpha_w = 24'($urandom);
        b0_w = 24'($urandom);
        b1_w = 24'($urandom);
        b2_w = 24'($urandom);
        a1_w = 24'($urandom);
        a2_w = 24'($urandom);
      end
      CFG_SLOW_ALPHA: begin
        // A realistic slow baseline with coefficients near the stable defaults.
        alpha_w = 24'($urandom_range(1, 65535));
        b0_w = 24'(int'(B0_RESET) + int'($urandom_range(0, 8190)) - 4095);
        b1_w = 24'(int'(B1_RESET) + int'($urandom_range(0, 8190)) - 4095);
        b2_w = 24'(int'(B2_RESET) + int'($urandom_range(0, 8190)) - 4095);
        a1_w = 24'(int'(A1_RESET) + int'($urandom_range(0, 8190)) - 4095);
        a2_w = 24'(int'(A2_RESET) + int'($urandom_range(0, 8190)) - 4095);
      end
      default: begin
        alpha_w = {1'b0, ALPHA_RESET};
        b0_w = B0_RESET;
        b1_w = B1_RESET;
        b2_w = B2_RESET;
        a1_w = A1_RESET;
        a2_w = A2_RESET;
      end
    endcase
    write_reg(REG_SPARE_LO, 24'($urandom));
    write_reg(REG_ALPHA, alpha_w);
    write_reg(REG_B0, b0_w);
    write_reg(REG_B1, b1_w);
    write_reg(REG_B2, b2_w);
    write_reg(REG_A1, a1_w);
    write_reg(REG_A2, a2_w);
    write_reg(REG_SPARE_HI, 24'($urandom));
    cfg_valid <= 1'b0;
    coef_settings++;
  endtask

  initial begin
    int level;
    int value;
    int pick;
    int reset_run[10];
    int swing_run[8];
    int floor_run[7];

    // The first sample loads the baseline directly, so it is full scale to
    // start the accumulator at its top; the rest mix the extremes with mid-scale.
    reset_run = '{FULL_SCALE, FULL_SCALE, 0, 0, FULL_SCALE, 1, 131072, 131071, 0, FULL_SCALE};
    swing_run = '{0, FULL_SCALE, 0, FULL_SCALE, FULL_SCALE, FULL_SCALE, 0, FULL_SCALE};
    floor_run = '{FULL_SCALE, 0, FULL_SCALE, 0, 1, FULL_SCALE - 1, 0};
    level = 100000;
    sb = new();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reset coefficients first, then the top extremes (baseline
    // and output saturation), then the bottom extremes.
    foreach (reset_run[i]) send_sample(reset_run[i][SAMPLE_BITS-1:0]);
    wait_for_results();
    load_coefs(CFG_MAX);
    foreach (swing_run[i]) send_sample(swing_run[i][SAMPLE_BITS-1:0]);
    wait_for_results();
    load_coefs(CFG_MIN);
    foreach (floor_run[i]) send_sample(floor_run[i][SAMPLE_BITS-1:0]);

    // Random phases. Most samples follow a drifting level with a pulse-sized
    // ripple on top, as a real sensor would; the rest are full-range noise,
    // rail values and single set bits.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_results();
      load_coefs(PHASE_KIND[p]);
      send_idle_pct  = SEND_IDLE[p % 4];
      recv_stall_pct = RECV_STALL[p % 4];
      pressure_phase = (p == PRESSURE_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          level += int'($urandom_range(0, 1024)) - 512;
          if (level < 0) level = 0;
          if (level > FULL_SCALE) level = FULL_SCALE;
          value = level + int'($urandom_range(0, 8191)) - 4096;
        end else if (pick < 85) begin
          value = $urandom_range(0, FULL_SCALE);
        end else if (pick < 90) begin
          value = 0;
        end else if (pick < 95) begin
          value = FULL_SCALE;
        end else begin
          value = 1 << $urandom_range(0, SAMPLE_BITS - 1);
        end
        if (value < 0) value = 0;
        if (value > FULL_SCALE) value = FULL_SCALE;
        send_sample(value[SAMPLE_BITS-1:0]);
      end
    end

    // Let any stray extra result show up before the verdict.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples under %0d coefficient sets with %0d register writes,",
             samples_sent, coef_settings, cfg_writes);
    $display("idle and stall mixes plus a %0d-cycle output hold-off; %0d results checked.",
             HOLD_OFF_CYCLES, sb.checked);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
